@@ sv/sed_pkg.sv @@
`default_nettype none

package sed_pkg;

   // operand width and derived sizes
   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DATA_WIDTH - 1);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX
   } sed_state_type;

   // control shared by every slice of the divider row
   typedef struct packed {
      logic load;
      logic step;
   } sed_cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/sed_cell.sv @@
`default_nettype none

module sed_cell (
   input  wire                        clock,
   input  wire sed_pkg::sed_cell_ctrl_type ctrl,
   input  wire                        load_q,
   input  wire                        load_d,
   input  wire                        t_in,
   input  wire                        q_shift_in,
   input  wire                        borrow_in,
   input  wire                        sel,
   output logic                       r_out,
   output logic                       q_out,
   output logic                       d_out,
   output logic                       borrow_out
);
   import sed_pkg::*;

   logic r_ff, r_in;
   logic q_ff, q_in;
   logic d_ff, d_in;
   logic diff;

   // one bit of the trial subtraction, borrow ripples to the next slice
   always_comb begin
      diff       = t_in ^ d_ff ^ borrow_in;
      borrow_out = (~t_in & d_ff) | (~(t_in ^ d_ff) & borrow_in);
   end

   // next value of the remainder, dividend/quotient and divisor bits
   always_comb begin
      r_in = r_ff;
      q_in = q_ff;
      d_in = d_ff;
      if (ctrl.load) begin
         r_in = 1'b0;
         q_in = load_q;
         d_in = load_d;
      end else if (ctrl.step) begin
         r_in = sel ? diff : t_in;
         q_in = q_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign r_out = r_ff;
   assign q_out = q_ff;
   assign d_out = d_ff;

endmodule

`default_nettype wire

@@ sv/sed_chain.sv @@
`default_nettype none

module sed_chain (
   input  wire                              clock,
   input  wire sed_pkg::sed_cell_ctrl_type  ctrl,
   input  wire [sed_pkg::DATA_WIDTH-1:0]    load_dividend,
   input  wire [sed_pkg::DATA_WIDTH-1:0]    load_divisor,
   output logic [sed_pkg::DATA_WIDTH-1:0]   quo,
   output logic [sed_pkg::DATA_WIDTH-1:0]   rem,
   output logic [sed_pkg::DATA_WIDTH-1:0]   div
);
   import sed_pkg::*;

   logic [DATA_WIDTH-1:0] r_bits;
   logic [DATA_WIDTH-1:0] q_bits;
   logic [DATA_WIDTH-1:0] d_bits;
   logic [DATA_WIDTH:0]   borrow;
   logic                  qbit;

   // subtract when the shifted remainder is not below the divisor
   assign borrow[0] = 1'b0;
   assign qbit      = r_bits[DATA_WIDTH-1] | ~borrow[DATA_WIDTH];

   // row of bit slices, each shifting into its upper neighbour
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_slice
      logic t_bit;
      logic q_bit_in;
      if (i == 0) begin : g_low
         assign t_bit    = q_bits[DATA_WIDTH-1];
         assign q_bit_in = qbit;
      end else begin : g_up
         assign t_bit    = r_bits[i-1];
         assign q_bit_in = q_bits[i-1];
      end
      sed_cell u_slice (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_q     (load_dividend[i]),
         .load_d     (load_divisor[i]),
         .t_in       (t_bit),
         .q_shift_in (q_bit_in),
         .borrow_in  (borrow[i]),
         .sel        (qbit),
         .r_out      (r_bits[i]),
         .q_out      (q_bits[i]),
         .d_out      (d_bits[i]),
         .borrow_out (borrow[i+1])
      );
   end

   assign quo = q_bits;
   assign rem = r_bits;
   assign div = d_bits;

endmodule

`default_nettype wire

@@ sv/signed_euclidean_divider.sv @@
`default_nettype none

// channel   direction  handshake           payload
// req_      in         req_valid/req_stall dividend, divisor (signed)
// rsp_      out        rsp_valid/rsp_stall quotient, remainder, divide_by_zero,
//                                          quotient_overflow
//
// a word loads the row of bit slices at its acceptance edge; DATA_WIDTH
// shift/subtract steps and a sign correction state follow, which waits for a
// free output register and writes it, so rsp_valid rises. one word is in the
// divider at a time; a new word is taken only once the sequencer is idle.
// reset is synchronous and active high; it clears the sequencer and rsp_valid.
// a stalled result holds in the output register while the next word is taken.

module signed_euclidean_divider (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire signed [sed_pkg::DATA_WIDTH-1:0]  req_dividend,
   input  wire signed [sed_pkg::DATA_WIDTH-1:0]  req_divisor,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [sed_pkg::DATA_WIDTH-1:0] rsp_quotient,
   output logic [sed_pkg::DATA_WIDTH-2:0]        rsp_remainder,
   output logic                                  rsp_divide_by_zero,
   output logic                                  rsp_quotient_overflow
);
   import sed_pkg::*;

   localparam logic [DATA_WIDTH:0]   HALF     = (DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MOST_NEG = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MOST_POS = ~MOST_NEG;

   sed_state_type state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic a_neg_ff, d_neg_ff, dz_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff;
   logic [DATA_WIDTH-2:0] rsp_remainder_ff;
   logic rsp_dz_ff, rsp_ovf_ff;

   logic req_accept, rsp_free, rsp_write;
   sed_cell_ctrl_type ctrl;
   logic [DATA_WIDTH-1:0] ua, ud;
   logic [DATA_WIDTH-1:0] qm, rm, dm;

   logic                  inc, q_neg, ovf;
   logic [DATA_WIDTH:0]   mag;
   logic [DATA_WIDTH-1:0] q_fix, r_fix;

   assign req_accept = req_valid & ~req_stall;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   // operand magnitudes
   always_comb begin
      ua = req_dividend[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - req_dividend) : req_dividend;
      ud = req_divisor[DATA_WIDTH-1]  ? (DATA_WIDTH'(0) - req_divisor)  : req_divisor;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == LAST_STEP) state_in = ST_FIX;
         ST_FIX:  if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      ctrl.load = 1'b0;
      ctrl.step = 1'b0;
      rsp_write = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctrl.load = req_valid;
         end
         ST_DIV:  ctrl.step = 1'b1;
         ST_FIX:  rsp_write = rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

   // step counter
   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept)
         cnt_in = '0;
      else if (state_ff == ST_DIV)
         cnt_in = cnt_ff + CNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (req_accept) begin
         a_neg_ff <= req_dividend[DATA_WIDTH-1];
         d_neg_ff <= req_divisor[DATA_WIDTH-1];
         dz_ff    <= (req_divisor == '0);
      end
   end

   // unsigned restoring division in the row of bit slices
   sed_chain u_chain (
      .clock         (clock),
      .ctrl          (ctrl),
      .load_dividend (ua),
      .load_divisor  (ud),
      .quo           (qm),
      .rem           (rm),
      .div           (dm)
   );

   // euclidean sign correction and saturation
   always_comb begin
      inc   = a_neg_ff & (rm != '0);
      mag   = {1'b0, qm} + (DATA_WIDTH+1)'(inc);
      q_neg = (a_neg_ff ^ d_neg_ff) & (mag != '0);
      r_fix = inc ? (dm - rm) : rm;
      if (q_neg) begin
         ovf   = (mag > HALF);
         q_fix = inc ? ~qm : (DATA_WIDTH'(0) - qm);
         if (ovf) q_fix = MOST_NEG;
      end else begin
         ovf   = (mag >= HALF);
         q_fix = mag[DATA_WIDTH-1:0];
         if (ovf) q_fix = MOST_POS;
      end
      if (ovf) r_fix = '0;
      if (dz_ff) begin
         ovf   = 1'b0;
         q_fix = '0;
         r_fix = '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_write)
         rsp_valid_in = 1'b1;
      else if (~rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write) begin
         rsp_quotient_ff  <= q_fix;
         rsp_remainder_ff <= r_fix[DATA_WIDTH-2:0];
         rsp_dz_ff        <= dz_ff;
         rsp_ovf_ff       <= ovf;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_quotient          = $signed(rsp_quotient_ff);
   assign rsp_remainder         = rsp_remainder_ff;
   assign rsp_divide_by_zero    = rsp_dz_ff;
   assign rsp_quotient_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ sv/sed_checker.sv @@
`default_nettype none

module sed_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_stall,
   input wire signed [sed_pkg::DATA_WIDTH-1:0] req_dividend,
   input wire signed [sed_pkg::DATA_WIDTH-1:0] req_divisor,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire signed [sed_pkg::DATA_WIDTH-1:0] rsp_quotient,
   input wire [sed_pkg::DATA_WIDTH-2:0]        rsp_remainder,
   input wire                                  rsp_divide_by_zero,
   input wire                                  rsp_quotient_overflow
);
   import sed_pkg::*;

   localparam logic [DATA_WIDTH-1:0] MOST_NEG = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder) && $stable(rsp_divide_by_zero)
         && $stable(rsp_quotient_overflow))
      else $error("result word changed while stalled");

   // one word in flight: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a word is in flight");

   // zero divisor gives zero outputs and no overflow
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0
         && rsp_remainder == '0 && !rsp_quotient_overflow)
      else $error("divide by zero word not cleared");

   // overflow saturates to the most positive quotient with zero remainder
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quotient_overflow |-> rsp_quotient == $signed(~MOST_NEG)
         && rsp_remainder == '0)
      else $error("overflow word not saturated");

endmodule

bind signed_euclidean_divider sed_checker u_checker (.*);

`default_nettype wire
